>>> hdl/assert_macros.svh
// assertion macros included by the core top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked assertion, disabled while reset is low
`define BTE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bte assertion failed");
// clocked assertion that also holds during reset
`define BTE_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bte assertion failed");
`else
`define BTE_ASSERT(label, clk, rst_n, prop)
`define BTE_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> hdl/bte_pkg.sv
// types and constants of the bitmap text glyph expander
package bte_pkg;

  localparam int unsigned FONT_BYTES_DEF   = 8192;
  localparam int unsigned MAX_GLYPH_WIDTH  = 16;
  localparam int unsigned MAX_GLYPH_HEIGHT = 16;
  localparam int unsigned MAX_SCALE        = 4;
  localparam int unsigned COORD_BITS       = 12;
  localparam int unsigned CURSOR_BITS      = COORD_BITS + 1;
  localparam int unsigned GADDR_W          = 14;
  localparam int unsigned GLYPH_WORD_W     = 16;
  localparam int unsigned ROW_BITS         = 64;
  localparam int unsigned ROW_IDX_W        = 6;
  localparam int unsigned LEN_W            = 7;
  localparam int unsigned CFG_ADDR_W       = 5;

  localparam logic [7:0] CHAR_END     = 8'd0;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_START = 2'd1,
    KIND_CHAR  = 2'd2
  } bte_kind_e;

  typedef enum logic [2:0] {
    REG_GLYPH_WIDTH  = 3'd0,
    REG_GLYPH_HEIGHT = 3'd1,
    REG_HSCALE       = 3'd2,
    REG_VSCALE       = 3'd3,
    REG_SCREEN_W     = 3'd4,
    REG_SCREEN_H     = 3'd5,
    REG_HIGHEST_CODE = 3'd6,
    REG_LAYOUT_MODE  = 3'd7
  } bte_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASS,
    S_EDGE,
    S_NEWLINE,
    S_FIT_X,
    S_FIT_Y,
    S_ADVANCE,
    S_FETCH_HI,
    S_FETCH_LO,
    S_FORM,
    S_SEND
  } bte_state_e;

endpackage

>>> hdl/bte_if.sv
// valid/ready channels for input items and pixel-row results
interface bte_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [12:0] font_address;
  logic [7:0]  font_data;
  logic [11:0] start_x;
  logic [11:0] start_y;
  logic [7:0]  char_code;

  modport source (output valid, kind, font_address, font_data, start_x, start_y, char_code,
                  input ready);
  modport sink   (input valid, kind, font_address, font_data, start_x, start_y, char_code,
                  output ready);
endinterface

interface bte_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] row_x;
  logic [11:0] row_y;
  logic [63:0] row_pixels;
  logic [6:0]  row_length;
  logic        last_row;

  modport source (output valid, row_x, row_y, row_pixels, row_length, last_row,
                  input ready);
  modport sink   (input valid, row_x, row_y, row_pixels, row_length, last_row,
                  output ready);
endinterface

>>> hdl/bitmap_text_glyph_expander_core.sv
// top level of the bitmap text glyph expander: font store, layout sequencer, row output
//
// A load beat writes one font byte and a start beat sets origin and cursor. A character
// beat runs a six-step layout sequence (classify, right edge, newline, fit in x, fit in
// y, advance) through one shared 14-bit add, compare and saturate unit, then emits
// glyph_height * vertical_scale pixel rows. Each glyph row costs one font memory read
// per byte (one or two, glyph widths up to 8 take one) and a form step, then is sent
// once per vertical repeat, each time held until the sink is ready. in_i.ready is low
// until the last row of the character has been taken.
// The font memory has no reset; bytes never loaded read back as unknown.
`include "assert_macros.svh"

module bitmap_text_glyph_expander_core import bte_pkg::*; #(
  parameter int unsigned FONT_BYTES = FONT_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bte_in_if.sink                in_i,
  bte_out_if.source             out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned FA_W  = $clog2(FONT_BYTES);
  localparam int unsigned IDX_W = (FA_W > GADDR_W) ? FA_W : GADDR_W;

  // configuration registers
  logic [4:0]  gw_q, gh_q;
  logic [2:0]  hs_q, vs_q;
  logic [11:0] scr_w_q, scr_h_q;
  logic [7:0]  hi_code_q;
  logic [1:0]  mode_q;

  // clamped and scaled geometry, registered every cycle
  logic [4:0]       w_c, w_q, h_c, h_q;
  logic [2:0]       xs_c, xs_q, ys_c, ys_q;
  logic [LEN_W-1:0] sw_c, sw_q, sh_c, sh_q, adv_c, adv_q;
  logic [1:0]       skip_c, skip_q;
  logic             two_c, two_q;
  logic [4:0]       w_clamp;

  // sequencer and layout state
  bte_state_e             state_q, state_d;
  logic [CURSOR_BITS-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [COORD_BITS-1:0]  origin_q, origin_d;
  logic                   stopped_q, stopped_d;
  logic [7:0]             code_q, code_d;
  logic                   nl_only_q, nl_only_d;
  logic                   fit_x_q, fit_x_d, fit_y_q, fit_y_d;

  // row emission
  logic [GADDR_W-1:0]    row_addr_q, row_addr_d;
  logic [4:0]            r_q, r_d;
  logic [2:0]            sy_q, sy_d;
  logic [7:0]            hi_q, hi_d;
  logic                  out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0] row_x_q, row_x_d, row_y_q, row_y_d;
  logic [ROW_BITS-1:0]   pix_q, pix_d, pix_c;
  logic [LEN_W-1:0]      len_q, len_d;
  logic                  last_q, last_d;

  // shared add / compare / saturate unit
  logic [CURSOR_BITS-1:0] alu_a;
  logic [LEN_W-1:0]       alu_b;
  logic [COORD_BITS-1:0]  alu_c;
  logic [GADDR_W-1:0]     alu_sum;
  logic                   alu_over;
  logic [CURSOR_BITS-1:0] alu_sat;

  // font memory
  logic [7:0]         font_mem [FONT_BYTES];
  logic [7:0]         rd_q, rd_byte;
  logic               rd_ok, rd_ok_q, wr_ok, mem_we;
  logic [GADDR_W-1:0] fetch_addr;
  logic [IDX_W-1:0]   wr_wide, rd_wide;

  logic        in_fire, cfg_we;
  logic        stop_class, is_newline, emit;
  logic [4:0]  h_last;
  logic [2:0]  ys_last;
  logic [12:0] glyph_prod;
  bte_reg_e    reg_sel;

  assign in_fire = in_i.valid && in_i.ready;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_sel = bte_reg_e'(paddr[4:2]);
  assign pready  = 1'b1;

  // ---------------------------------------------------------------- configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q      <= 5'd8;
      gh_q      <= 5'd16;
      hs_q      <= 3'd1;
      vs_q      <= 3'd1;
      scr_w_q   <= 12'd640;
      scr_h_q   <= 12'd480;
      hi_code_q <= 8'd127;
      mode_q    <= 2'd3;
    end else if (cfg_we) begin
      case (reg_sel)
        REG_GLYPH_WIDTH:  gw_q      <= pwdata[4:0];
        REG_GLYPH_HEIGHT: gh_q      <= pwdata[4:0];
        REG_HSCALE:       hs_q      <= pwdata[2:0];
        REG_VSCALE:       vs_q      <= pwdata[2:0];
        REG_SCREEN_W:     scr_w_q   <= pwdata[11:0];
        REG_SCREEN_H:     scr_h_q   <= pwdata[11:0];
        REG_HIGHEST_CODE: hi_code_q <= pwdata[7:0];
        REG_LAYOUT_MODE:  mode_q    <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_GLYPH_WIDTH:  prdata = 32'(gw_q);
      REG_GLYPH_HEIGHT: prdata = 32'(gh_q);
      REG_HSCALE:       prdata = 32'(hs_q);
      REG_VSCALE:       prdata = 32'(vs_q);
      REG_SCREEN_W:     prdata = 32'(scr_w_q);
      REG_SCREEN_H:     prdata = 32'(scr_h_q);
      REG_HIGHEST_CODE: prdata = 32'(hi_code_q);
      REG_LAYOUT_MODE:  prdata = 32'(mode_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- geometry
  always_comb begin
    // width clamped, then rounded down to even
    if (gw_q < 5'd2) begin
      w_clamp = 5'd2;
    end else if (gw_q > 5'(MAX_GLYPH_WIDTH)) begin
      w_clamp = 5'(MAX_GLYPH_WIDTH);
    end else begin
      w_clamp = gw_q;
    end
    w_c = {w_clamp[4:1], 1'b0};
    if (gh_q < 5'd1) begin
      h_c = 5'd1;
    end else if (gh_q > 5'(MAX_GLYPH_HEIGHT)) begin
      h_c = 5'(MAX_GLYPH_HEIGHT);
    end else begin
      h_c = gh_q;
    end
    if (hs_q < 3'd1) begin
      xs_c = 3'd1;
    end else if (hs_q > 3'(MAX_SCALE)) begin
      xs_c = 3'(MAX_SCALE);
    end else begin
      xs_c = hs_q;
    end
    if (vs_q < 3'd1) begin
      ys_c = 3'd1;
    end else if (vs_q > 3'(MAX_SCALE)) begin
      ys_c = 3'(MAX_SCALE);
    end else begin
      ys_c = vs_q;
    end
    sw_c  = LEN_W'(w_c) * LEN_W'(xs_c);
    sh_c  = LEN_W'(h_c) * LEN_W'(ys_c);
    two_c = w_c > 5'd8;
    // widths off a byte boundary sit centred and advance one column short
    if (w_c[2:0] == 3'd0) begin
      skip_c = 2'd0;
      adv_c  = sw_c;
    end else begin
      skip_c = 2'((4'd8 - 4'(w_c[2:0])) >> 1);
      adv_c  = LEN_W'(w_c - 5'd1) * LEN_W'(xs_c);
    end
  end

  always_ff @(posedge clk_i) begin
    w_q    <= w_c;
    h_q    <= h_c;
    xs_q   <= xs_c;
    ys_q   <= ys_c;
    sw_q   <= sw_c;
    sh_q   <= sh_c;
    adv_q  <= adv_c;
    skip_q <= skip_c;
    two_q  <= two_c;
  end

  assign h_last  = h_q - 5'd1;
  assign ys_last = ys_q - 3'd1;

  // ---------------------------------------------------------------- shared unit
  always_comb begin
    case (state_q)
      S_NEWLINE, S_FIT_Y: begin
        alu_a = cy_q;
        alu_b = sh_q;
        alu_c = scr_h_q;
      end
      S_ADVANCE: begin
        alu_a = cx_q;
        alu_b = adv_q;
        alu_c = scr_w_q;
      end
      default: begin
        alu_a = cx_q;
        alu_b = sw_q;
        alu_c = scr_w_q;
      end
    endcase
    alu_sum  = GADDR_W'(alu_a) + GADDR_W'(alu_b);
    alu_over = alu_sum > GADDR_W'(alu_c);
    // cursor saturates at all ones
    alu_sat  = alu_sum[GADDR_W-1] ? '1 : alu_sum[CURSOR_BITS-1:0];
  end

  assign stop_class = (12'(sw_q) > scr_w_q) || (12'(sh_q) > scr_h_q) || (code_q == CHAR_END);
  assign is_newline = (code_q == CHAR_NEWLINE) && mode_q[1];
  assign emit       = (code_q <= hi_code_q) && fit_x_q && fit_y_q;
  assign glyph_prod = 13'(code_q) * 13'(h_q);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && (in_i.kind == KIND_CHAR) && !stopped_q) begin
          state_d = S_CLASS;
        end
      end
      S_CLASS: begin
        if (stop_class) begin
          state_d = S_IDLE;
        end else if (is_newline) begin
          state_d = S_NEWLINE;
        end else begin
          state_d = S_EDGE;
        end
      end
      S_EDGE: begin
        if (!alu_over) begin
          state_d = S_FIT_X;
        end else if (mode_q[0]) begin
          state_d = S_NEWLINE;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_NEWLINE:  state_d = nl_only_q ? S_IDLE : S_FIT_X;
      S_FIT_X:    state_d = S_FIT_Y;
      S_FIT_Y:    state_d = S_ADVANCE;
      S_ADVANCE:  state_d = emit ? S_FETCH_HI : S_IDLE;
      S_FETCH_HI: state_d = two_q ? S_FETCH_LO : S_FORM;
      S_FETCH_LO: state_d = S_FORM;
      S_FORM:     state_d = S_SEND;
      S_SEND: begin
        if (out_o.ready && (sy_q == ys_last)) begin
          state_d = (r_q == h_last) ? S_IDLE : S_FETCH_HI;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath updates
  always_comb begin
    cx_d        = cx_q;
    cy_d        = cy_q;
    origin_d    = origin_q;
    stopped_d   = stopped_q;
    code_d      = code_q;
    nl_only_d   = nl_only_q;
    fit_x_d     = fit_x_q;
    fit_y_d     = fit_y_q;
    row_addr_d  = row_addr_q;
    r_d         = r_q;
    sy_d        = sy_q;
    hi_d        = hi_q;
    out_valid_d = out_valid_q;
    row_x_d     = row_x_q;
    row_y_d     = row_y_q;
    pix_d       = pix_q;
    len_d       = len_q;
    last_d      = last_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_i.kind)
            KIND_START: begin
              origin_d  = in_i.start_x;
              cx_d      = CURSOR_BITS'(in_i.start_x);
              cy_d      = CURSOR_BITS'(in_i.start_y);
              stopped_d = 1'b0;
            end
            KIND_CHAR: code_d = in_i.char_code;
            default: ;
          endcase
        end
      end
      S_CLASS: begin
        nl_only_d = 1'b1;
        if (stop_class) begin
          stopped_d = 1'b1;
        end
      end
      S_EDGE: begin
        nl_only_d = 1'b0;
        if (alu_over) begin
          if (mode_q[0]) begin
            cx_d = CURSOR_BITS'(origin_q);
          end else begin
            stopped_d = 1'b1;
          end
        end
      end
      S_NEWLINE: begin
        cx_d = CURSOR_BITS'(origin_q);
        cy_d = alu_sat;
      end
      S_FIT_X: fit_x_d = !alu_over;
      S_FIT_Y: begin
        fit_y_d    = !alu_over;
        row_addr_d = two_q ? {glyph_prod, 1'b0} : {1'b0, glyph_prod};
        r_d        = '0;
        row_x_d    = cx_q[COORD_BITS-1:0];
        row_y_d    = cy_q[COORD_BITS-1:0];
        len_d      = sw_q;
      end
      S_ADVANCE: cx_d = alu_sat;
      S_FETCH_HI: sy_d = '0;
      S_FETCH_LO: hi_d = rd_byte;
      S_FORM: begin
        pix_d       = pix_c;
        out_valid_d = 1'b1;
        last_d      = (r_q == h_last) && (sy_q == ys_last);
      end
      S_SEND: begin
        if (out_o.ready) begin
          row_y_d = row_y_q + 12'd1;
          if (sy_q != ys_last) begin
            // same glyph row again, one screen row down
            sy_d   = sy_q + 3'd1;
            last_d = (r_q == h_last) && ((sy_q + 3'd1) == ys_last);
          end else begin
            out_valid_d = 1'b0;
            if (r_q != h_last) begin
              r_d        = r_q + 5'd1;
              row_addr_d = row_addr_q + (two_q ? GADDR_W'(2) : GADDR_W'(1));
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cx_q        <= '0;
      cy_q        <= '0;
      origin_q    <= '0;
      stopped_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      origin_q    <= origin_d;
      stopped_q   <= stopped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q     <= code_d;
    nl_only_q  <= nl_only_d;
    fit_x_q    <= fit_x_d;
    fit_y_q    <= fit_y_d;
    row_addr_q <= row_addr_d;
    r_q        <= r_d;
    sy_q       <= sy_d;
    hi_q       <= hi_d;
    row_x_q    <= row_x_d;
    row_y_q    <= row_y_d;
    pix_q      <= pix_d;
    len_q      <= len_d;
    last_q     <= last_d;
  end

  // ---------------------------------------------------------------- font memory
  // high byte of a two-byte row is read first
  assign fetch_addr = row_addr_q +
                      (((state_q == S_FETCH_HI) && two_q) ? GADDR_W'(1) : GADDR_W'(0));
  assign rd_ok      = 32'(fetch_addr) < 32'(FONT_BYTES);
  assign wr_ok      = 32'(in_i.font_address) < 32'(FONT_BYTES);
  assign mem_we     = in_fire && (in_i.kind == KIND_LOAD) && wr_ok;
  assign wr_wide    = IDX_W'(in_i.font_address);
  assign rd_wide    = IDX_W'(fetch_addr);
  // reads past the end of the store come back as zero
  assign rd_byte    = rd_ok_q ? rd_q : 8'h00;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      font_mem[wr_wide[FA_W-1:0]] <= in_i.font_data;
    end
    rd_q    <= font_mem[rd_wide[FA_W-1:0]];
    rd_ok_q <= rd_ok;
  end

  bte_row_unit u_row (
    .hi_i        (hi_q),
    .lo_i        (rd_byte),
    .two_bytes_i (two_q),
    .skip_i      (skip_q),
    .width_i     (w_q),
    .xscale_i    (xs_q),
    .length_i    (sw_q),
    .pixels_o    (pix_c)
  );

  // ---------------------------------------------------------------- ports
  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.row_x      = row_x_q;
  assign out_o.row_y      = row_y_q;
  assign out_o.row_pixels = pix_q;
  assign out_o.row_length = len_q;
  assign out_o.last_row   = last_q;

  // ---------------------------------------------------------------- assertions
  `BTE_ASSERT(a_busy_while_row_out, clk_i, rst_ni, out_o.valid |-> !in_i.ready)
  `BTE_ASSERT(a_last_row_frees_input, clk_i, rst_ni, (out_o.valid && out_o.ready && out_o.last_row) |=> in_i.ready)
  `BTE_ASSERT(a_row_length_is_scaled_width, clk_i, rst_ni, out_o.valid |-> (out_o.row_length == sw_q))
  `BTE_ASSERT(a_no_pixels_past_length, clk_i, rst_ni, out_o.valid |-> ((out_o.row_pixels >> out_o.row_length) == 64'b0))

endmodule

>>> hdl/bte_row_unit.sv
// expands one glyph row into a horizontally scaled pixel mask
module bte_row_unit import bte_pkg::*; (
  input  logic [7:0]          hi_i,
  input  logic [7:0]          lo_i,
  input  logic                two_bytes_i,
  input  logic [1:0]          skip_i,
  input  logic [4:0]          width_i,
  input  logic [2:0]          xscale_i,
  input  logic [LEN_W-1:0]    length_i,
  output logic [ROW_BITS-1:0] pixels_o
);

  logic [GLYPH_WORD_W-1:0] word;
  logic [GLYPH_WORD_W-1:0] shifted;
  logic [GLYPH_WORD_W-1:0] glyph;
  logic [ROW_BITS-1:0]     glyph_ext;
  logic [ROW_IDX_W-1:0]    col;

  always_comb begin
    // first drawn bit lands at the top of the word once the skip is shifted out
    word      = two_bytes_i ? {hi_i, lo_i} : {lo_i, 8'h00};
    shifted   = word << skip_i;
    for (int j = 0; j < GLYPH_WORD_W; j++) begin
      glyph[j] = shifted[GLYPH_WORD_W-1-j] && (5'(j) < width_i);
    end
    glyph_ext = ROW_BITS'(glyph);
    col       = '0;
    pixels_o  = '0;
    for (int p = 0; p < ROW_BITS; p++) begin
      case (xscale_i)
        3'd1:    col = ROW_IDX_W'(p);
        3'd2:    col = ROW_IDX_W'(p / 2);
        3'd3:    col = ROW_IDX_W'(p / 3);
        default: col = ROW_IDX_W'(p / 4);
      endcase
      pixels_o[p] = (LEN_W'(p) < length_i) && glyph_ext[col];
    end
  end

endmodule

>>> sim/testbench.sv
// self-checking testbench for the bitmap text glyph expander core
`timescale 1ns / 1ps

module testbench;
  import bte_pkg::*;

  // kind code that the block ignores
  localparam logic [1:0]  KIND_IGNORED   = 2'd3;
  localparam int unsigned CURSOR_LIMIT   = (1 << CURSOR_BITS) - 1;
  // cycles to let a character that draws nothing finish before a register write
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned FINAL_CYCLES   = 40;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned RANDOM_BEATS   = 210;
  localparam int unsigned RANDOM_PHASES  = 6;

  typedef struct {
    logic [1:0]  kind;
    logic [12:0] font_address;
    logic [7:0]  font_data;
    logic [11:0] start_x;
    logic [11:0] start_y;
    logic [7:0]  char_code;
  } text_beat_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [63:0] pixels;
    logic [6:0]  len;
    logic        last;
  } pixel_row_t;

  typedef struct {
    logic [4:0]  width;
    logic [4:0]  height;
    logic [2:0]  hscale;
    logic [2:0]  vscale;
    logic [11:0] screen_w;
    logic [11:0] screen_h;
    logic [7:0]  top_code;
    logic [1:0]  layout;
  } layout_regs_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bte_in_if  text_if ();
  bte_out_if rows_if ();

  // predictor state: font copy, cursor, origin, stop flag and registers
  logic [7:0]             font_mem [FONT_BYTES_DEF];
  bit                     font_known [FONT_BYTES_DEF];
  logic [CURSOR_BITS-1:0] pen_x;
  logic [CURSOR_BITS-1:0] pen_y;
  logic [11:0]            origin_col;
  bit                     halted;
  layout_regs_t           regs;

  // rows still owed by the block, oldest first
  pixel_row_t  rows_due [$];
  int unsigned fail_count;
  int unsigned quiet_cycles;
  int unsigned feed_idle_odds;
  int unsigned sink_idle_odds;
  bit          hold_rows;

  bitmap_text_glyph_expander_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (text_if),
    .out_o   (rows_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned clamp_to(input int unsigned v, input int unsigned lo,
                                           input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // glyph width in use: clamped and forced even
  function automatic int unsigned glyph_cols();
    return clamp_to(regs.width, 2, MAX_GLYPH_WIDTH) & ~32'd1;
  endfunction

  function automatic int unsigned glyph_rows();
    return clamp_to(regs.height, 1, MAX_GLYPH_HEIGHT);
  endfunction

  // cursor add that sticks at the all-ones value
  function automatic logic [CURSOR_BITS-1:0] cursor_add(input logic [CURSOR_BITS-1:0] a,
                                                        input int unsigned d);
    int unsigned s;
    s = a + d;
    return (s > CURSOR_LIMIT) ? CURSOR_BITS'(CURSOR_LIMIT) : CURSOR_BITS'(s);
  endfunction

  // apply one accepted beat to the predictor and queue the rows it draws
  function automatic void advance_text(input text_beat_t b);
    int unsigned w, h, xs, ys, sw, sh, part, nbytes, skip, base, len;
    logic        bit_val;
    logic [63:0] mask;
    pixel_row_t  row;
    case (b.kind)
      KIND_LOAD: begin
        font_mem[b.font_address] = b.font_data;
        font_known[b.font_address] = 1'b1;
      end
      KIND_START: begin
        origin_col = b.start_x;
        pen_x = {1'b0, b.start_x};
        pen_y = {1'b0, b.start_y};
        halted = 1'b0;
      end
      KIND_CHAR: begin
        if (halted) return;
        w  = glyph_cols();
        h  = glyph_rows();
        xs = clamp_to(regs.hscale, 1, MAX_SCALE);
        ys = clamp_to(regs.vscale, 1, MAX_SCALE);
        sw = w * xs;
        sh = h * ys;
        // glyph larger than the screen, or end of string
        if (sw > regs.screen_w || sh > regs.screen_h || b.char_code == CHAR_END) begin
          halted = 1'b1;
          return;
        end
        if (b.char_code == CHAR_NEWLINE && regs.layout[1]) begin
          pen_x = origin_col;
          pen_y = cursor_add(pen_y, sh);
          return;
        end
        if (pen_x + sw > regs.screen_w) begin
          if (!regs.layout[0]) begin
            halted = 1'b1;
            return;
          end
          pen_x = origin_col;
          pen_y = cursor_add(pen_y, sh);
        end
        if (b.char_code <= regs.top_code && pen_x + sw <= regs.screen_w &&
            pen_y + sh <= regs.screen_h) begin
          part   = w % 8;
          nbytes = (w + 7) / 8;
          skip   = (part != 0) ? (8 - part) / 2 : 0;
          base   = nbytes * b.char_code * h;
          for (int unsigned r = 0; r < h; r++) begin
            for (int unsigned sy = 0; sy < ys; sy++) begin
              mask = '0;
              len  = 0;
              // highest byte first, msb first; narrow fonts lose their edge bits
              for (int k = nbytes - 1; k >= 0; k--) begin
                for (int bi = 7; bi >= 0; bi--) begin
                  if (part != 0 && k == nbytes - 1 && bi + skip > 7) continue;
                  if (part != 0 && k == 0 && bi < skip) continue;
                  bit_val = font_mem[base + r * nbytes + k][bi];
                  repeat (xs) begin
                    if (len < 64) begin
                      mask[len] = bit_val;
                      len++;
                    end
                  end
                end
              end
              row.x      = pen_x[11:0];
              row.y      = 12'(pen_y + r * ys + sy);
              row.pixels = mask;
              row.len    = 7'(len);
              row.last   = (r == h - 1 && sy == ys - 1);
              rows_due.push_back(row);
            end
          end
        end
        // the advance keeps the width-minus-one quirk for narrow fonts
        pen_x = cursor_add(pen_x, (w % 8 != 0) ? (w - 1) * xs : sw);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // shared stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic text_beat_t random_beat();
    text_beat_t b;
    b.kind         = 2'($urandom_range(0, 3));
    b.font_address = 13'($urandom);
    b.font_data    = 8'($urandom);
    b.start_x      = 12'($urandom);
    b.start_y      = 12'($urandom);
    b.char_code    = 8'($urandom);
    return b;
  endfunction

  // offer one beat, sometimes after a random gap, and wait until it is taken
  task automatic send_beat(input text_beat_t b);
    if (feed_idle_odds != 0 && $urandom_range(1, feed_idle_odds) == 1) begin
      text_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    text_if.valid        <= 1'b1;
    text_if.kind         <= b.kind;
    text_if.font_address <= b.font_address;
    text_if.font_data    <= b.font_data;
    text_if.start_x      <= b.start_x;
    text_if.start_y      <= b.start_y;
    text_if.char_code    <= b.char_code;
    @(posedge clk_i);
    while (text_if.ready !== 1'b1) @(posedge clk_i);
    advance_text(b);
  endtask

  // load random bytes into any part of a glyph that was never written,
  // so a drawn character never reads an unloaded font byte
  task automatic load_glyph(input logic [7:0] code);
    int unsigned nbytes, first, span;
    text_beat_t  b;
    if (code == CHAR_END || code > regs.top_code) return;
    nbytes = (glyph_cols() + 7) / 8;
    span   = nbytes * glyph_rows();
    first  = nbytes * code * glyph_rows();
    for (int unsigned a = first; a < first + span; a++) begin
      if (!font_known[a]) begin
        b = random_beat();
        b.kind = KIND_LOAD;
        b.font_address = 13'(a);
        send_beat(b);
      end
    end
  endtask

  task automatic send_char(input logic [7:0] code);
    text_beat_t b;
    load_glyph(code);
    b = random_beat();
    b.kind = KIND_CHAR;
    b.char_code = code;
    send_beat(b);
  endtask

  task automatic send_start(input int unsigned x, input int unsigned y);
    text_beat_t b;
    b = random_beat();
    b.kind = KIND_START;
    b.start_x = 12'(x);
    b.start_y = 12'(y);
    send_beat(b);
  endtask

  // drop valid, wait for every owed row, then let a quiet character finish
  task automatic settle(input int unsigned extra);
    text_if.valid <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // apb write: setup phase, then access phase
  task automatic write_reg(input bte_reg_e idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GLYPH_WIDTH:  regs.width    = value[4:0];
      REG_GLYPH_HEIGHT: regs.height   = value[4:0];
      REG_HSCALE:       regs.hscale   = value[2:0];
      REG_VSCALE:       regs.vscale   = value[2:0];
      REG_SCREEN_W:     regs.screen_w = value[11:0];
      REG_SCREEN_H:     regs.screen_h = value[11:0];
      REG_HIGHEST_CODE: regs.top_code = value[7:0];
      REG_LAYOUT_MODE:  regs.layout   = value[1:0];
      default: ;
    endcase
  endtask

  task automatic set_layout(input int unsigned w, input int unsigned h, input int unsigned xs,
                            input int unsigned ys, input int unsigned sw, input int unsigned sh,
                            input int unsigned top, input int unsigned mode);
    settle(SETTLE_CYCLES);
    write_reg(REG_GLYPH_WIDTH, w);
    write_reg(REG_GLYPH_HEIGHT, h);
    write_reg(REG_HSCALE, xs);
    write_reg(REG_VSCALE, ys);
    write_reg(REG_SCREEN_W, sw);
    write_reg(REG_SCREEN_H, sh);
    write_reg(REG_HIGHEST_CODE, top);
    write_reg(REG_LAYOUT_MODE, mode);
  endtask

  function automatic logic [7:0] pick_code();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(32, 126));
    if (r < 80) return CHAR_NEWLINE;
    if (r < 85) return CHAR_END;
    return 8'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset register values: stop after reset, ignored kind, wrap, newline,
  // codes above the font, end of string, off-screen glyphs
  task automatic test_reset_layout();
    text_beat_t b;
    send_char(8'd65);
    b = random_beat();
    b.kind = KIND_IGNORED;
    send_beat(b);
    send_start(0, 0);
    send_char(8'd65);
    send_char(8'd66);
    send_char(8'd200);
    send_char(CHAR_END);
    send_char(8'd67);
    // last column that still fits, then a wrap back to the origin
    send_start(632, 0);
    send_char(8'd65);
    send_char(8'd65);
    send_char(CHAR_NEWLINE);
    send_char(8'd68);
    send_start(0, 470);
    send_char(8'd65);
    send_start(4095, 4095);
    send_char(8'd65);
  endtask

  // widest and tallest glyph, smallest glyph, centred narrow fonts,
  // and registers outside their legal range
  task automatic test_glyph_geometry();
    set_layout(16, 16, 4, 4, 4095, 4095, 255, 3);
    send_start(0, 0);
    send_char(8'd255);
    set_layout(2, 1, 1, 1, 4095, 4095, 255, 3);
    send_start(0, 0);
    send_char(8'd1);
    send_char(8'd254);
    set_layout(12, 2, 3, 2, 640, 480, 127, 3);
    send_start(5, 7);
    send_char(8'd7);
    set_layout(31, 0, 0, 7, 640, 480, 127, 3);
    send_start(0, 0);
    send_char(8'd3);
    set_layout(7, 3, 5, 0, 640, 480, 127, 3);
    send_start(0, 0);
    send_char(8'd4);
    set_layout(0, 31, 7, 2, 640, 480, 127, 3);
    send_start(0, 0);
    send_char(8'd9);
  endtask

  // each layout mode, oversized glyphs and an empty font range
  task automatic test_layout_modes();
    // no wrap: the third character runs off the right edge and stops the string
    set_layout(8, 4, 1, 1, 40, 64, 127, 0);
    send_start(24, 0);
    send_char(8'd97);
    send_char(8'd98);
    send_char(8'd99);
    send_char(8'd100);
    // newline drawn as a glyph when not honoured
    send_start(0, 0);
    send_char(CHAR_NEWLINE);
    set_layout(8, 4, 1, 1, 40, 64, 127, 2);
    send_start(0, 0);
    send_char(CHAR_NEWLINE);
    send_char(8'd65);
    set_layout(8, 4, 1, 1, 40, 64, 127, 1);
    send_start(16, 0);
    send_char(CHAR_NEWLINE);
    send_char(8'd65);
    send_char(8'd66);
    // scaled glyph wider, then taller, than the screen
    set_layout(8, 4, 2, 1, 15, 64, 127, 3);
    send_start(0, 0);
    send_char(8'd65);
    send_char(8'd66);
    set_layout(8, 4, 1, 3, 64, 11, 127, 3);
    send_start(0, 0);
    send_char(8'd65);
    set_layout(8, 4, 1, 1, 64, 64, 0, 3);
    send_start(0, 0);
    send_char(8'd1);
    send_char(8'd2);
  endtask

  // newlines push the cursor row past the top of its range; it must stick
  // there instead of wrapping back onto the screen
  task automatic test_cursor_saturation();
    set_layout(16, 16, 1, 4, 4095, 4095, 127, 3);
    send_start(0, 4095);
    repeat (66) send_char(CHAR_NEWLINE);
    send_char(8'd65);
  endtask

  // the row sink stops for a long stretch while characters keep coming
  task automatic test_back_pressure();
    set_layout(8, 4, 2, 2, 640, 480, 127, 3);
    for (int c = 65; c < 73; c++) load_glyph(8'(c));
    send_start(0, 0);
    hold_rows = 1'b1;
    for (int c = 65; c < 73; c++) send_char(8'(c));
  endtask

  task automatic random_layout();
    int unsigned w, h, xs, ys, sw, sh, top;
    w  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 16);
    h  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 8);
    xs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
    ys = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 2);
    case ($urandom_range(0, 9))
      0:       sw = $urandom_range(1, 12);
      1:       sw = 4095;
      default: sw = $urandom_range(64, 320);
    endcase
    case ($urandom_range(0, 9))
      0:       sh = $urandom_range(1, 12);
      1:       sh = 4095;
      default: sh = $urandom_range(32, 200);
    endcase
    case ($urandom_range(0, 3))
      0:       top = 255;
      1:       top = 127;
      2:       top = 126;
      default: top = $urandom_range(0, 255);
    endcase
    set_layout(w, h, xs, ys, sw, sh, top, $urandom_range(0, 3));
  endtask

  // mostly well-formed strings with random text, mixed with loads,
  // ignored kinds and strays
  task automatic test_random_text();
    int unsigned made, sel;
    text_beat_t  b;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_layout();
      // some phases run with no gaps on one side
      feed_idle_odds = (ph % 3 == 2) ? 0 : $urandom_range(3, 10);
      sink_idle_odds = (ph % 3 == 1) ? 0 : $urandom_range(3, 10);
      made = 0;
      while (made < RANDOM_BEATS / RANDOM_PHASES) begin
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
          send_start($urandom_range(0, regs.screen_w), $urandom_range(0, regs.screen_h / 2));
          made++;
          repeat ($urandom_range(1, 10)) begin
            send_char(pick_code());
            made++;
          end
        end else if (sel < 88) begin
          b = random_beat();
          b.kind = KIND_LOAD;
          send_beat(b);
          made++;
        end else if (sel < 94) begin
          b = random_beat();
          b.kind = KIND_IGNORED;
          send_beat(b);
        end else begin
          send_start($urandom_range(0, 4095), $urandom_range(0, 4095));
          send_char(8'($urandom));
          made += 2;
        end
      end
    end
  endtask

  task automatic test_streaming();
    set_layout(10, 5, 1, 1, 200, 120, 127, 3);
    send_start(3, 2);
    repeat (20) send_char(pick_code());
  endtask

  // ---------------------------------------------------------------------------
  // row sink: random stalls, plus a long hold when asked for one
  // ---------------------------------------------------------------------------
  initial begin : row_sink
    int unsigned waited;
    rows_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_rows) begin
        rows_if.ready <= 1'b0;
        for (waited = 0; waited < HOLD_CYCLES; waited++) @(posedge clk_i);
        hold_rows = 1'b0;
      end else if (sink_idle_odds != 0 && $urandom_range(1, sink_idle_odds) == 1) begin
        rows_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        rows_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // row checker: every taken row against the oldest owed row
  // ---------------------------------------------------------------------------
  function automatic void note_field(input string name, input logic [63:0] want,
                                     input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : row_check
    pixel_row_t want;
    if (rst_ni && rows_if.valid === 1'b1 && rows_if.ready === 1'b1) begin
      if (rows_due.size() == 0) begin
        $display("%0t: row with none owed, x=%h y=%h pixels=%h", $time,
                 rows_if.row_x, rows_if.row_y, rows_if.row_pixels);
        fail_count++;
      end else begin
        want = rows_due.pop_front();
        note_field("row_x", want.x, rows_if.row_x);
        note_field("row_y", want.y, rows_if.row_y);
        note_field("row_pixels", want.pixels, rows_if.row_pixels);
        note_field("row_length", want.len, rows_if.row_length);
        note_field("last_row", want.last, rows_if.last_row);
      end
    end
  end

  // watchdog: too long without a beat on either channel ends the run
  always @(posedge clk_i) begin
    if ((text_if.valid === 1'b1 && text_if.ready === 1'b1) ||
        (rows_if.valid === 1'b1 && rows_if.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of tests
  // ---------------------------------------------------------------------------
  initial begin
    text_if.valid        <= 1'b0;
    text_if.kind         <= KIND_LOAD;
    text_if.font_address <= '0;
    text_if.font_data    <= '0;
    text_if.start_x      <= '0;
    text_if.start_y      <= '0;
    text_if.char_code    <= '0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    // predictor starts from the block's reset state
    regs       = '{5'd8, 5'd16, 3'd1, 3'd1, 12'd640, 12'd480, 8'd127, 2'd3};
    pen_x      = '0;
    pen_y      = '0;
    origin_col = '0;
    halted     = 1'b1;
    fail_count = 0;
    quiet_cycles = 0;
    hold_rows  = 1'b0;
    feed_idle_odds = 4;
    sink_idle_odds = 4;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_layout();
    test_glyph_geometry();
    test_layout_modes();
    test_cursor_saturation();
    test_back_pressure();
    test_random_text();
    // last stretch runs with both sides always willing
    feed_idle_odds = 0;
    sink_idle_odds = 0;
    test_streaming();

    settle(FINAL_CYCLES);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
